// ----- design/ffr_pkg.sv -----
package ffr_pkg;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // field widths
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int MODE_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 9'd256;

    // transform modes
    localparam logic [MODE_W-1:0] MODE_FLIP_H = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLIP_V = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd4;

    // input actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // control for one memory access
    typedef struct packed {
        logic valid;
        logic rd;
        logic last;
    } t_mem_ctl;

endpackage

// ----- design/ffr_in_if.sv -----
interface ffr_in_if
    import ffr_pkg::*;
    ();
    logic            valid;
    logic            ready;
    logic            action;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, action, red, green, blue, input ready);
    modport sink   (input valid, action, red, green, blue, output ready);
endinterface

// ----- design/ffr_out_if.sv -----
interface ffr_out_if
    import ffr_pkg::*;
    ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            last_pixel;

    modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

// ----- design/ffr_cfg.sv -----
module ffr_cfg
    import ffr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WDW = $clog2(MAX_WIDTH + 1),
    localparam int HDW = $clog2(MAX_HEIGHT + 1),
    localparam int AW0 = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int AW  = (AW0 < 1) ? 1 : AW0,
    localparam int TW  = AW + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [WDW-1:0]        o_w,
    output logic [HDW-1:0]        o_h,
    output logic [TW-1:0]         o_total,
    output logic [MODE_W-1:0]     o_mode,
    output logic                  o_settle
);

    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic [MODE_W-1:0]     r_mode;
    logic                  r_settle;
    logic [TW-1:0]         r_total;
    logic [WDW+HDW-1:0]    prod;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_mode         <= MODE_FLIP_H;
            r_settle       <= 1'b1;
        end else begin
            r_settle <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data;
                    REG_TRANSFORM_MODE: r_mode         <= i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // clamp sizes into 1..max
    always_comb begin
        if (r_frame_width == '0) begin
            o_w = WDW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            o_w = WDW'(MAX_WIDTH);
        end else begin
            o_w = WDW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            o_h = HDW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            o_h = HDW'(MAX_HEIGHT);
        end else begin
            o_h = HDW'(r_frame_height);
        end
    end

    // pixel count of the frame, registered; the input is held off after a write while it settles
    assign prod = (WDW+HDW)'(o_w) * (WDW+HDW)'(o_h);

    always_ff @(posedge i_clk) begin
        r_total <= prod[TW-1:0];
    end

    assign o_total  = r_total;
    assign o_mode   = r_mode;
    assign o_settle = r_settle;

endmodule

// ----- design/ffr_addr.sv -----
module ffr_addr
    import ffr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WDW = $clog2(MAX_WIDTH + 1),
    localparam int HDW = $clog2(MAX_HEIGHT + 1),
    localparam int CW0 = $clog2(MAX_WIDTH),
    localparam int CW  = (CW0 < 1) ? 1 : CW0,
    localparam int RW0 = $clog2(MAX_HEIGHT),
    localparam int RW  = (RW0 < 1) ? 1 : RW0,
    localparam int DW  = (CW > RW) ? CW : RW,
    localparam int OWW = (WDW > HDW) ? WDW : HDW,
    localparam int AW0 = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int AW  = (AW0 < 1) ? 1 : AW0,
    localparam int TW  = AW + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_take,
    input  logic              i_action,
    input  logic [PIX_W-1:0]  i_pix,
    input  logic [WDW-1:0]    i_w,
    input  logic [HDW-1:0]    i_h,
    input  logic [TW-1:0]     i_total,
    input  logic [MODE_W-1:0] i_mode,
    output t_mem_ctl          o_ctl,
    output logic [AW-1:0]     o_addr,
    output logic [PIX_W-1:0]  o_pix
);

    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [AW-1:0]      r_rpos;

    logic [CW:0]        c_cur;
    logic [RW:0]        r_cur;
    logic [CW:0]        c_nxt;
    logic [RW:0]        r_nxt;
    logic [CW-1:0]      x;
    logic [RW-1:0]      y;
    logic [DW-1:0]      u;
    logic [DW-1:0]      v;
    logic [OWW-1:0]     ow;
    logic [AW-1:0]      p;
    logic [TW-1:0]      p_inc;
    logic               p_last;

    t_mem_ctl           r1_ctl;
    logic [DW-1:0]      r1_u;
    logic [DW-1:0]      r1_v;
    logic [OWW-1:0]     r1_ow;
    logic [AW-1:0]      r1_raddr;
    logic [PIX_W-1:0]   r1_pix;
    logic [DW+OWW-1:0]  lin;

    t_mem_ctl           r2_ctl;
    logic [AW-1:0]      r2_addr;
    logic [PIX_W-1:0]   r2_pix;

    // source position, wrapped into the current frame, and the one after it
    always_comb begin
        c_cur = {1'b0, r_col};
        r_cur = {1'b0, r_row};
        if (c_cur >= i_w) begin
            c_cur = '0;
            r_cur = r_cur + 1'b1;
        end
        if (r_cur >= i_h) begin
            r_cur = '0;
        end
        x = c_cur[CW-1:0];
        y = r_cur[RW-1:0];
        c_nxt = c_cur + 1'b1;
        r_nxt = r_cur;
        if (c_nxt >= i_w) begin
            c_nxt = '0;
            r_nxt = r_cur + 1'b1;
            if (r_nxt >= i_h) begin
                r_nxt = '0;
            end
        end
    end

    // destination coordinates for the transform
    always_comb begin
        case (i_mode)
            MODE_FLIP_H: begin
                u  = DW'(i_w - 1'b1 - x);
                v  = DW'(y);
                ow = OWW'(i_w);
            end
            MODE_FLIP_V: begin
                u  = DW'(x);
                v  = DW'(i_h - 1'b1 - y);
                ow = OWW'(i_w);
            end
            MODE_ROT90: begin
                u  = DW'(i_h - 1'b1 - y);
                v  = DW'(x);
                ow = OWW'(i_h);
            end
            MODE_ROT180: begin
                u  = DW'(i_w - 1'b1 - x);
                v  = DW'(i_h - 1'b1 - y);
                ow = OWW'(i_w);
            end
            MODE_ROT270: begin
                u  = DW'(y);
                v  = DW'(i_w - 1'b1 - x);
                ow = OWW'(i_h);
            end
            default: begin
                u  = DW'(x);
                v  = DW'(y);
                ow = OWW'(i_w);
            end
        endcase
    end

    // readout position, wrapped into the current frame
    always_comb begin
        p      = (TW'(r_rpos) >= i_total) ? '0 : r_rpos;
        p_inc  = TW'(p) + 1'b1;
        p_last = (p_inc == i_total);
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rpos <= '0;
        end else if (i_take) begin
            if (i_action == ACT_WRITE) begin
                r_col <= c_nxt[CW-1:0];
                r_row <= r_nxt[RW-1:0];
            end else begin
                r_rpos <= p_last ? '0 : p_inc[AW-1:0];
            end
        end
    end

    // stage 1: coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_adv) begin
            r1_ctl.valid <= i_take;
            r1_ctl.rd    <= (i_action == ACT_READ);
            r1_ctl.last  <= p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_u     <= u;
            r1_v     <= v;
            r1_ow    <= ow;
            r1_raddr <= p;
            r1_pix   <= i_pix;
        end
    end

    // stage 2: linear address
    assign lin = (DW+OWW)'(r1_v) * (DW+OWW)'(r1_ow) + (DW+OWW)'(r1_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_adv) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_addr <= r1_ctl.rd ? r1_raddr : lin[AW-1:0];
            r2_pix  <= r1_pix;
        end
    end

    assign o_ctl  = r2_ctl;
    assign o_addr = r2_addr;
    assign o_pix  = r2_pix;

endmodule

// ----- design/ffr_store.sv -----
module ffr_store
    import ffr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW0   = $clog2(DEPTH),
    localparam int AW    = (AW0 < 1) ? 1 : AW0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_mem_ctl         i_ctl,
    input  logic [AW-1:0]    i_addr,
    input  logic [PIX_W-1:0] i_pix,
    output logic             o_valid,
    output logic             o_last,
    output logic [PIX_W-1:0] o_pix
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;
    logic             r_valid;
    logic             r_last;

    // frame memory, one access per cycle while the pipeline advances, registered read
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_ctl.valid && !i_ctl.rd) begin
                mem[i_addr] <= i_pix;
            end
            r_rdata <= mem[i_addr];
            r_last  <= i_ctl.last;
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid && i_ctl.rd;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_pix   = r_rdata;

endmodule

// ----- design/frame_flip_rotate.sv -----
// Frame flip and rotate engine.
// Input channel i_pix carries one word per item: action 0 writes the next
// source pixel (red, green, blue) in raster order, action 1 reads the next
// pixel of the transformed frame. Each write is stored straight at its
// transformed address, so readout is a plain raster sweep of the memory.
// Output channel o_pix returns one word per read, with last_pixel set on the
// final pixel of the frame; writes give no word.
// Registers frame_width, frame_height and transform_mode are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle (a user rule, not
// enforced); the input is held off after each write while the frame size
// product settles. Reads pass the coordinate, address multiply and memory
// read stages. One item is taken per cycle unless the output stalls or a write
// settles; the memory does one write or one read per cycle while the pipeline
// advances. When the receiver stalls on a waiting word, the whole pipeline
// holds and i_pix.ready drops. Reset clears the counters, pipeline and
// registers (256 x 256, flip horizontal); memory is undefined until written.
module frame_flip_rotate
    import ffr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ffr_in_if.sink                i_pix,
    ffr_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int AW0 = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int AW  = (AW0 < 1) ? 1 : AW0;
    localparam int TW  = AW + 1;

    logic [WDW-1:0]    w;
    logic [HDW-1:0]    h;
    logic [TW-1:0]     total;
    logic [MODE_W-1:0] mode;
    logic              settle;
    logic              adv;
    logic              take;
    t_mem_ctl          ctl;
    logic [AW-1:0]     addr;
    logic [PIX_W-1:0]  wpix;
    logic              st_valid;
    logic              st_last;
    logic [PIX_W-1:0]  st_pix;

    // pipeline moves unless the output word is stuck
    assign adv         = !st_valid || o_pix.ready;
    assign i_pix.ready = adv && !settle;
    assign take        = i_pix.valid && i_pix.ready;

    ffr_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_w        (w),
        .o_h        (h),
        .o_total    (total),
        .o_mode     (mode),
        .o_settle   (settle)
    );

    ffr_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_take   (take),
        .i_action (i_pix.action),
        .i_pix    ({i_pix.red, i_pix.green, i_pix.blue}),
        .i_w      (w),
        .i_h      (h),
        .i_total  (total),
        .i_mode   (mode),
        .o_ctl    (ctl),
        .o_addr   (addr),
        .o_pix    (wpix)
    );

    ffr_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (ctl),
        .i_addr  (addr),
        .i_pix   (wpix),
        .o_valid (st_valid),
        .o_last  (st_last),
        .o_pix   (st_pix)
    );

    // output word
    assign o_pix.valid      = st_valid;
    assign o_pix.out_red    = st_pix[3*CH_W-1:2*CH_W];
    assign o_pix.out_green  = st_pix[2*CH_W-1:CH_W];
    assign o_pix.out_blue   = st_pix[CH_W-1:0];
    assign o_pix.last_pixel = st_last;

endmodule
